>>> src/sss_pkg.sv
// Shared types, constants and code tables of the seven-segment scan shifter.
`default_nettype none
package sss_pkg;

  localparam int unsigned ValueWidth = 14;
  localparam int unsigned BcdWidth   = 16;
  localparam int unsigned DdSteps    = ValueWidth;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ValueWidth-1:0] ValueMax = 14'd9999;

  localparam logic [1:0] LastDigit = 2'd3;
  localparam logic [3:0] LastBit   = 4'd15;
  localparam logic [3:0] LatchBit  = 4'd7;

  typedef logic [BcdWidth-1:0] bcd_t;

  // Occupancy flags of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Common-anode segment byte, active low.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      default: code = 8'h90;
    endcase
    return code;
  endfunction

  // Digit-select byte, rotated by one for the cascaded registers.
  function automatic logic [7:0] sel_code(input logic [1:0] digit);
    logic [7:0] code;
    unique case (digit)
      2'd0: code = 8'h02;
      2'd1: code = 8'h04;
      2'd2: code = 8'h08;
      2'd3: code = 8'h01;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

>>> src/sss_front.sv
// Front end: accepts a value, saturates it and converts it to BCD one bit a cycle.
`default_nettype none
module sss_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [13:0]        in_value_i,
  input  wire sss_pkg::q_status_t q_status_i,
  output logic                    push_o,
  output sss_pkg::bcd_t           push_data_o
);
  import sss_pkg::*;

  logic                  busy_q, busy_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  bcd_t                  bcd_q, bcd_d;
  bcd_t                  bcd_adj;
  logic                  done;
  logic                  accept;
  logic [ValueWidth-1:0] value_sat;

  assign value_sat = (in_value_i > ValueMax) ? ValueMax : in_value_i;

  assign done       = busy_q && (cnt_q == 5'(DdSteps));
  assign push_o     = done && !q_status_i.full;
  assign push_data_o = bcd_q;
  assign in_stall_o = busy_q && !push_o;
  assign accept     = in_valid_i && !in_stall_o;

  // Add three to every nibble of five or more before the shift.
  always_comb begin
    for (int n = 0; n < BcdWidth / 4; n++) begin
      bcd_adj[n*4 +: 4] = (bcd_q[n*4 +: 4] >= 4'd5) ? bcd_q[n*4 +: 4] + 4'd3
                                                    : bcd_q[n*4 +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = value_sat;
      bcd_d  = '0;
    end else if (push_o) begin
      busy_d = 1'b0;
    end else if (busy_q && !done) begin
      cnt_d = cnt_q + 5'd1;
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule
`default_nettype wire

>>> src/sss_fifo.sv
// Short queue of converted digit sets between the front and back ends.
`default_nettype none
module sss_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [Width-1:0]   push_data_i,
  input  wire logic               pop_i,
  output logic [Width-1:0]        pop_data_o,
  output sss_pkg::q_status_t      status_o
);
  import sss_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

>>> src/sss_back.sv
// Back end: serializes segment and select bytes into one bit beat per cycle unless out_stall_i holds it.
`default_nettype none
module sss_back #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sss_pkg::q_status_t q_status_i,
  input  wire sss_pkg::bcd_t      pop_data_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    out_data_bit_o,
  output logic                    out_latch_after_o,
  output logic [1:0]              out_digit_index_o,
  output logic                    out_last_o
);
  import sss_pkg::*;

  localparam int unsigned NdClamp = (NUM_DIGITS < 1) ? 1 :
                                    (NUM_DIGITS > 4) ? 4 : NUM_DIGITS;
  localparam logic [1:0] FirstDigit = 2'(4 - NdClamp);

  logic       active_q;
  bcd_t       digits_q;
  logic [1:0] dig_q;
  logic [3:0] bit_q;
  logic       out_valid_q;
  logic       data_q, latch_q, last_q;
  logic [1:0] index_q;

  logic       adv, emit, at_last;
  logic [3:0] digit;
  logic [7:0] cur_byte;

  assign adv     = !out_valid_q || !out_stall_i;
  assign emit    = adv && active_q;
  assign at_last = (dig_q == LastDigit) && (bit_q == LastBit);
  assign pop_o   = !q_status_i.empty && (!active_q || (emit && at_last));

  always_comb begin
    unique case (dig_q)
      2'd0: digit = digits_q[15:12];
      2'd1: digit = digits_q[11:8];
      2'd2: digit = digits_q[7:4];
      2'd3: digit = digits_q[3:0];
    endcase
  end

  assign cur_byte = bit_q[3] ? sel_code(dig_q) : seg_code(digit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      dig_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        dig_q    <= FirstDigit;
        bit_q    <= '0;
      end else if (emit) begin
        if (at_last) active_q <= 1'b0;
        bit_q <= bit_q + 4'd1;
        if (bit_q == LastBit) dig_q <= dig_q + 2'd1;
      end
      if (adv) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) digits_q <= pop_data_i;
    if (emit) begin
      data_q  <= cur_byte[~bit_q[2:0]];
      latch_q <= (bit_q == LatchBit);
      last_q  <= at_last;
      index_q <= dig_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_bit_o    = data_q;
  assign out_latch_after_o = latch_q;
  assign out_digit_index_o = index_q;
  assign out_last_o        = last_q;

endmodule
`default_nettype wire

>>> src/seven_segment_scan_shifter_unit.sv
// Top level of the four-digit seven-segment shift register scan driver.
//
// Usage: the host offers one binary value per display scan on the input
// channel (in_valid_i, in_stall_o, in_value_i). Values above 9999 show as 9999.
// Each value makes 16 * NUM_DIGITS beats (clamped 1..4), one per shift clock:
// eight segment bits MSB first with a latch pulse after the eighth, then the
// eight bits of the digit-select byte. out_last_o marks the final beat.
// The front end converts the value to decimal one bit per cycle and takes no
// new value before it pushes the result. A two-entry queue decouples it
// from the back end, which emits one beat per cycle unless stalled, so the
// serializer sets the sustained rate. A value passes the converter, the queue
// and the back end's digit and output registers before its first beat shows.
// When the receiver raises out_stall_i the current beat holds in the output
// register; the queue and the front end keep accepting until they are full.
// Reset clears all control state; no scan is in flight after reset.
`default_nettype none
module seven_segment_scan_shifter_unit #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [13:0] in_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_data_bit_o,
  output logic             out_latch_after_o,
  output logic [1:0]       out_digit_index_o,
  output logic             out_last_o
);
  import sss_pkg::*;

  // Handshake between the front end and the queue.
  logic      push;
  bcd_t      push_data;
  // Handshake between the queue and the back end.
  logic      pop;
  bcd_t      pop_data;
  q_status_t q_status;

  sss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_value_i  (in_value_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sss_fifo #(
    .Depth (QueueDepth),
    .Width (BcdWidth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  sss_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_status_i        (q_status),
    .pop_data_i        (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_bit_o    (out_data_bit_o),
    .out_latch_after_o (out_latch_after_o),
    .out_digit_index_o (out_digit_index_o),
    .out_last_o        (out_last_o)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue overflow");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue underflow");

  // After taking a value the front end is busy converting it.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front end accepted during conversion");

  // The final beat of a scan belongs to the units digit and carries no latch.
  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |-> (out_digit_index_o == LastDigit) && !out_latch_after_o)
    else $error("bad final beat");

endmodule
`default_nettype wire
